[hw/rtl/triangle_box_clipper_top_macros.svh]
// Assertion macros shared by the triangle box clipper RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef TRIANGLE_BOX_CLIPPER_TOP_MACROS_SVH
`define TRIANGLE_BOX_CLIPPER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define TBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbc check failed");
// Next-cycle implication, disabled while in reset
`define TBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbc check failed");
`else
`define TBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TBC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/tbc_pkg.sv]
// Shared types, widths and constants of the triangle box clipper.
// No dependencies; imported by the top level, the distance and interpolation units and the testbench.
package tbc_pkg;

    localparam int CW        = 20;  // Q13.6 coordinate
    localparam int VW        = 60;  // packed vertex x, y, z
    localparam int DW        = 40;  // plane distance, Q.20
    localparam int AXW       = 48;  // packed axis
    localparam int RADW      = 19;  // radius and epsilon
    localparam int RAM_DEPTH = 32;  // two banks of sixteen vertex slots
    localparam int RAM_AW    = 5;

    localparam logic [3:0]  POLY_MAX     = 4'd9;
    localparam logic [10:0] OUTPUT_VERTS = 11'd1024;
    localparam logic [2:0]  LAST_PLANE   = 3'd5;

    typedef enum logic [1:0] {
        SIDE_ON     = 2'd0,
        SIDE_AHEAD  = 2'd1,
        SIDE_BEHIND = 2'd2
    } side_t;

    typedef struct packed {
        logic signed [DW-1:0] plane_dist;
        side_t                side;
    } dist_res_t;

    typedef enum logic [2:0] {
        REG_AXIS_ZERO    = 3'd0,
        REG_AXIS_ONE     = 3'd1,
        REG_AXIS_TWO     = 3'd2,
        REG_BOX_ORIGIN   = 3'd3,
        REG_BOX_RADIUS   = 3'd4,
        REG_ON_EPSILON   = 3'd5,
        REG_MAX_VERTICES = 3'd6
    } cfg_reg_t;

    // Sign-extend a coordinate by one bit
    function automatic logic signed [CW:0] coord_ext(input logic [CW-1:0] c);
        return {c[CW-1], c};
    endfunction

endpackage

[hw/rtl/tbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/tbc_dist.sv]
// Plane distance unit: one 21x16 multiplier, three products accumulated.
// Depends on tbc_pkg.
module tbc_dist (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tbc_pkg::VW-1:0]     vtx,
    input  logic [tbc_pkg::AXW-1:0]    axis,
    input  logic [tbc_pkg::VW-1:0]     origin,
    input  logic [tbc_pkg::RADW-1:0]   radius,
    input  logic [tbc_pkg::RADW-1:0]   epsilon,
    input  logic                       flip,
    output tbc_pkg::dist_res_t         res,
    output logic                       done
);
    import tbc_pkg::*;

    logic                 busy_reg;
    logic [2:0]           cnt_reg;
    logic [VW-1:0]        vtx_reg;
    logic signed [36:0]   prod_reg;
    logic signed [DW-1:0] acc_reg;
    dist_res_t            res_reg;
    logic                 done_reg;

    logic signed [CW:0]   diff;
    logic signed [15:0]   a_sel;
    logic signed [36:0]   prod_full;
    logic signed [DW-1:0] acc_flip;
    logic signed [DW-1:0] dist_f;
    logic signed [DW-1:0] eps_f;
    logic signed [DW-1:0] rad_f;

    // Pick the component for this step
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                diff  = coord_ext(vtx_reg[19:0]) - coord_ext(origin[19:0]);
                a_sel = axis[15:0];
            end
            2'd1:
            begin
                diff  = coord_ext(vtx_reg[39:20]) - coord_ext(origin[39:20]);
                a_sel = axis[31:16];
            end
            default:
            begin
                diff  = coord_ext(vtx_reg[59:40]) - coord_ext(origin[59:40]);
                a_sel = axis[47:32];
            end
        endcase
    end

    assign prod_full = diff * a_sel;

    // Finish: orient, add radius, classify against the tolerance band
    assign acc_flip = flip ? -acc_reg : acc_reg;
    assign rad_f    = $signed({{(DW-RADW-14){1'b0}}, radius, 14'b0});
    assign eps_f    = $signed({{(DW-RADW-14){1'b0}}, epsilon, 14'b0});
    assign dist_f   = acc_flip + rad_f;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vtx_reg <= vtx;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg <= 3'd2)
            begin
                prod_reg <= prod_full;
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd3)
            begin
                acc_reg <= acc_reg + DW'(prod_reg);
            end
            if (cnt_reg == 3'd4)
            begin
                res_reg.plane_dist <= dist_f;
                if (dist_f > eps_f)
                begin
                    res_reg.side <= SIDE_AHEAD;
                end
                else if (dist_f < -eps_f)
                begin
                    res_reg.side <= SIDE_BEHIND;
                end
                else
                begin
                    res_reg.side <= SIDE_ON;
                end
            end
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

[hw/rtl/tbc_interp.sv]
// Edge interpolation unit: shift-add multiplier and restoring divider
// shared over the three coordinates. Depends on tbc_pkg.
module tbc_interp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tbc_pkg::VW-1:0]      v_vtx,
    input  logic [tbc_pkg::VW-1:0]      w_vtx,
    input  logic signed [tbc_pkg::DW-1:0] dv,
    input  logic signed [tbc_pkg::DW-1:0] dw,
    output logic [tbc_pkg::VW-1:0]      res,
    output logic                        done
);
    import tbc_pkg::*;

    typedef enum logic [4:0] {
        IS_IDLE = 5'b00001,
        IS_LOAD = 5'b00010,
        IS_MUL  = 5'b00100,
        IS_PREP = 5'b01000,
        IS_DIV  = 5'b10000
    } istate_t;

    istate_t       state_reg;
    logic [1:0]    coord_reg;
    logic [4:0]    cnt_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [61:0]   pr_reg;
    logic [41:0]   rem_reg;
    logic [21:0]   qn_reg;
    logic [VW-1:0] res_reg;

    logic signed [DW:0] den;
    logic [DW:0]        den_mag;
    logic [DW-1:0]      dv_mag;
    logic [41:0]        dvs;
    logic [CW-1:0]      v_c;
    logic [CW-1:0]      w_c;
    logic signed [CW:0] diff;
    logic [CW:0]        diff_mag;
    logic [41:0]        mul_sum;
    logic [62:0]        num_n;
    logic [42:0]        trial;
    logic               ge;
    logic signed [22:0] sum_v;
    logic [CW-1:0]      sat_v;

    // Shared edge terms; operands are held by the sequencer throughout
    assign den     = DW'(dv) - DW'(dw) + 41'sd0;
    assign den_mag = den[DW] ? (DW+1)'(-den) : den;
    assign dv_mag  = dv[DW-1] ? DW'(-dv) : DW'(dv);
    assign dvs     = {den_mag, 1'b0};

    always_comb
    begin
        case (coord_reg)
            2'd0:
            begin
                v_c = v_vtx[19:0];
                w_c = w_vtx[19:0];
            end
            2'd1:
            begin
                v_c = v_vtx[39:20];
                w_c = w_vtx[39:20];
            end
            default:
            begin
                v_c = v_vtx[59:40];
                w_c = w_vtx[59:40];
            end
        endcase
    end

    assign diff     = coord_ext(w_c) - coord_ext(v_c);
    assign diff_mag = diff[CW] ? (CW+1)'(-diff) : diff;

    // One multiplier bit per step
    assign mul_sum = {1'b0, pr_reg[61:21]} + (pr_reg[0] ? {2'b0, dv_mag} : 42'd0);
    // Rounding numerator 2*|num| + |den|
    assign num_n   = {1'b0, pr_reg[60:0], 1'b0} + {22'b0, den_mag};
    // One quotient bit per step
    assign trial   = {rem_reg, qn_reg[21]};
    assign ge      = trial >= {1'b0, dvs};

    // Apply the rounded step and saturate
    assign sum_v = {{3{v_c[CW-1]}}, v_c} + (neg_reg ? -$signed({1'b0, qn_reg})
                                                  : $signed({1'b0, qn_reg}));
    always_comb
    begin
        if (sum_v > 23'sd524287)
        begin
            sat_v = 20'h7FFFF;
        end
        else if (sum_v < -23'sd524288)
        begin
            sat_v = 20'h80000;
        end
        else
        begin
            sat_v = sum_v[CW-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IS_IDLE;
            coord_reg <= 2'd0;
            cnt_reg   <= 5'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                IS_IDLE:
                begin
                    if (start)
                    begin
                        coord_reg <= 2'd0;
                        state_reg <= IS_LOAD;
                    end
                end
                IS_LOAD:
                begin
                    cnt_reg   <= 5'd0;
                    state_reg <= IS_MUL;
                end
                IS_MUL:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd20)
                    begin
                        state_reg <= IS_PREP;
                    end
                end
                IS_PREP:
                begin
                    cnt_reg   <= 5'd0;
                    state_reg <= IS_DIV;
                end
                IS_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd22)
                    begin
                        if (coord_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= IS_IDLE;
                        end
                        else
                        begin
                            coord_reg <= coord_reg + 2'd1;
                            state_reg <= IS_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IS_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            IS_LOAD:
            begin
                pr_reg  <= {41'b0, diff_mag};
                neg_reg <= diff[CW] ^ dv[DW-1] ^ den[DW];
            end
            IS_MUL:
            begin
                pr_reg <= {mul_sum, pr_reg[20:1]};
            end
            IS_PREP:
            begin
                rem_reg <= {1'b0, num_n[62:22]};
                qn_reg  <= num_n[21:0];
            end
            IS_DIV:
            begin
                if (cnt_reg == 5'd22)
                begin
                    case (coord_reg)
                        2'd0:    res_reg[19:0]  <= sat_v;
                        2'd1:    res_reg[39:20] <= sat_v;
                        default: res_reg[59:40] <= sat_v;
                    endcase
                end
                else
                begin
                    rem_reg <= ge ? 42'(trial - {1'b0, dvs}) : trial[41:0];
                    qn_reg  <= {qn_reg[20:0], ge};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

[hw/rtl/triangle_box_clipper_top.sv]
// Triangle box clipper top level: sequencer, vertex RAM and config registers.
// Depends on tbc_pkg, tbc_ram, tbc_dist, tbc_interp and the assertion macros.
//
// Usage: one triangle enters on the s_axis channel (tuser = start_batch).
// It is clipped against the six planes of the configured oriented box and
// the surviving polygon leaves on m_axis as 3 to 9 vertex transfers, tlast
// on the final one. A dropped triangle produces no transfer at all.
// The block takes one triangle at a time and s_axis_tready is low while it
// works. Per triangle it loads the three vertices into the vertex RAM, then
// for each plane classifies every vertex with the distance unit and
// interpolates a new vertex on each crossing edge, with the serial multiplier
// and divider that produce the interpolated vertex one bit per cycle.
// Output vertices are held in an output register; a stalled receiver holds
// the sequencer before the next vertex, and the last vertex may wait there
// while the next triangle is already taken.
// Reset clears the vertex count and restores the default configuration.
// Write configuration through cfg_we/cfg_index/cfg_data only when idle.
`include "triangle_box_clipper_top_macros.svh"
module triangle_box_clipper_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (20 bits each), zero pad
    input  logic [183:0] s_axis_tdata,
    // start_batch
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z (20 each), buffer_index (10), poly_size (4), pad
    output logic [79:0]  m_axis_tdata,
    // last
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [59:0]  cfg_data
);
    import tbc_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_LOAD   = 16'h0002,
        S_FETCH0 = 16'h0004,
        S_RD0    = 16'h0008,
        S_D0     = 16'h0010,
        S_NEXT   = 16'h0020,
        S_NRD    = 16'h0040,
        S_ND     = 16'h0080,
        S_KEEP   = 16'h0100,
        S_IWAIT  = 16'h0200,
        S_ADV    = 16'h0400,
        S_PEND   = 16'h0800,
        S_FINAL  = 16'h1000,
        S_ORD    = 16'h2000,
        S_OLD    = 16'h4000,
        S_SPARE  = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration
    logic [AXW-1:0]  axis0_reg;
    logic [AXW-1:0]  axis1_reg;
    logic [AXW-1:0]  axis2_reg;
    logic [VW-1:0]   origin_reg;
    logic [RADW-1:0] radius_reg;
    logic [RADW-1:0] eps_reg;
    logic [10:0]     maxv_reg;

    // Control
    logic [1:0]  lcnt_reg;
    logic        bank_reg;
    logic [2:0]  plane_reg;
    logic [3:0]  n_reg;
    logic [3:0]  f_reg;
    logic [3:0]  i_reg;
    logic [3:0]  e_reg;
    logic        front_reg;
    logic        over_reg;
    logic        wrap_reg;
    logic [10:0] used_reg;
    logic        out_valid_reg;

    // Payload
    logic [179:0]  tri_reg;
    logic [VW-1:0] first_p_reg;
    logic [VW-1:0] cur_p_reg;
    logic [VW-1:0] nxt_p_reg;
    dist_res_t     first_d_reg;
    dist_res_t     cur_d_reg;
    dist_res_t     nxt_d_reg;
    logic [VW-1:0] out_v_reg;
    logic [9:0]    out_idx_reg;
    logic [3:0]    out_size_reg;
    logic          out_last_reg;

    logic              in_xfer;
    logic              ram_we;
    logic [3:0]        ram_wr_idx;
    logic [VW-1:0]     ram_wr_data;
    logic [3:0]        rd_idx;
    logic [VW-1:0]     ram_rd_data;
    logic              dist_start;
    logic              dist_done;
    dist_res_t         dist_res;
    logic [AXW-1:0]    axis_sel;
    logic              interp_start;
    logic              interp_done;
    logic [VW-1:0]     interp_res;
    logic              crossing;
    logic              keep_cur;
    logic              out_load;
    logic              out_is_last;
    logic [10:0]       budget;
    logic [11:0]       used_sum;
    logic [VW-1:0]     load_vtx;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    assign keep_cur = (cur_d_reg.side != SIDE_BEHIND);
    assign crossing = (cur_d_reg.side != SIDE_ON) && (nxt_d_reg.side != SIDE_ON)
                      && (cur_d_reg.side != nxt_d_reg.side);

    assign budget   = (maxv_reg > OUTPUT_VERTS) ? OUTPUT_VERTS : maxv_reg;
    assign used_sum = {1'b0, used_reg} + {8'b0, n_reg};

    assign out_load    = (state_reg == S_OLD) && (!out_valid_reg || m_axis_tready);
    assign out_is_last = (e_reg == n_reg - 4'd1);

    // Select the axis of the current plane pair
    always_comb
    begin
        case (plane_reg[2:1])
            2'd0:    axis_sel = axis0_reg;
            2'd1:    axis_sel = axis1_reg;
            default: axis_sel = axis2_reg;
        endcase
    end

    // Triangle vertex for the load sweep
    always_comb
    begin
        case (lcnt_reg)
            2'd0:    load_vtx = tri_reg[59:0];
            2'd1:    load_vtx = tri_reg[119:60];
            default: load_vtx = tri_reg[179:120];
        endcase
    end

    // RAM read address
    always_comb
    begin
        rd_idx = i_reg + 4'd1;
        if (state_reg == S_FETCH0)
        begin
            rd_idx = 4'd0;
        end
        else if (state_reg == S_ORD || state_reg == S_OLD)
        begin
            rd_idx = e_reg;
        end
    end

    // RAM write: triangle load into the source bank, survivors into the other
    always_comb
    begin
        ram_we      = 1'b0;
        ram_wr_idx  = f_reg;
        ram_wr_data = cur_p_reg;
        if (state_reg == S_LOAD)
        begin
            ram_we      = 1'b1;
            ram_wr_idx  = {2'b0, lcnt_reg};
            ram_wr_data = load_vtx;
        end
        else if (state_reg == S_KEEP)
        begin
            ram_we = keep_cur && (f_reg < POLY_MAX);
        end
        else if (state_reg == S_IWAIT)
        begin
            ram_we      = interp_done && (f_reg < POLY_MAX);
            ram_wr_data = interp_res;
        end
    end

    assign dist_start   = (state_reg == S_RD0) || (state_reg == S_NRD);
    assign interp_start = (state_reg == S_KEEP) && crossing;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_xfer) state_next = S_LOAD;
            S_LOAD:   if (lcnt_reg == 2'd2) state_next = S_FETCH0;
            S_FETCH0: state_next = S_RD0;
            S_RD0:    state_next = S_D0;
            S_D0:     if (dist_done) state_next = S_NEXT;
            S_NEXT:   state_next = (i_reg + 4'd1 == n_reg) ? S_KEEP : S_NRD;
            S_NRD:    state_next = S_ND;
            S_ND:     if (dist_done) state_next = S_KEEP;
            S_KEEP:   state_next = crossing ? S_IWAIT : S_ADV;
            S_IWAIT:  if (interp_done) state_next = S_ADV;
            S_ADV:    state_next = wrap_reg ? S_PEND : S_NEXT;
            S_PEND:
            begin
                if (!front_reg || over_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = (plane_reg == LAST_PLANE) ? S_FINAL : S_FETCH0;
                end
            end
            S_FINAL:
            begin
                if (n_reg < 4'd3 || used_sum > {1'b0, budget})
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ORD;
                end
            end
            S_ORD:    state_next = S_OLD;
            S_OLD:
            begin
                if (out_load)
                begin
                    state_next = out_is_last ? S_IDLE : S_ORD;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis0_reg     <= 48'h0000_0000_4000;
            axis1_reg     <= 48'h0000_4000_0000;
            axis2_reg     <= 48'h4000_0000_0000;
            origin_reg    <= '0;
            radius_reg    <= '0;
            eps_reg       <= 19'd6;
            maxv_reg      <= 11'd1024;
            lcnt_reg      <= 2'd0;
            bank_reg      <= 1'b0;
            plane_reg     <= 3'd0;
            n_reg         <= 4'd0;
            f_reg         <= 4'd0;
            i_reg         <= 4'd0;
            e_reg         <= 4'd0;
            front_reg     <= 1'b0;
            over_reg      <= 1'b0;
            wrap_reg      <= 1'b0;
            used_reg      <= 11'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AXIS_ZERO:    axis0_reg  <= cfg_data[AXW-1:0];
                    REG_AXIS_ONE:     axis1_reg  <= cfg_data[AXW-1:0];
                    REG_AXIS_TWO:     axis2_reg  <= cfg_data[AXW-1:0];
                    REG_BOX_ORIGIN:   origin_reg <= cfg_data;
                    REG_BOX_RADIUS:   radius_reg <= cfg_data[RADW-1:0];
                    REG_ON_EPSILON:   eps_reg    <= cfg_data[RADW-1:0];
                    REG_MAX_VERTICES: maxv_reg   <= cfg_data[10:0];
                    default:
                    begin
                    end
                endcase
            end

            // Output register valid: set on load, drop after transfer
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        lcnt_reg  <= 2'd0;
                        bank_reg  <= 1'b0;
                        plane_reg <= 3'd0;
                        n_reg     <= 4'd3;
                        if (s_axis_tuser)
                        begin
                            used_reg <= 11'd0;
                        end
                    end
                end
                S_LOAD:
                begin
                    lcnt_reg <= lcnt_reg + 2'd1;
                end
                S_FETCH0:
                begin
                    f_reg     <= 4'd0;
                    i_reg     <= 4'd0;
                    front_reg <= 1'b0;
                    over_reg  <= 1'b0;
                end
                S_D0:
                begin
                    if (dist_done && dist_res.side == SIDE_AHEAD)
                    begin
                        front_reg <= 1'b1;
                    end
                end
                S_NEXT:
                begin
                    wrap_reg <= (i_reg + 4'd1 == n_reg);
                end
                S_ND:
                begin
                    if (dist_done && dist_res.side == SIDE_AHEAD)
                    begin
                        front_reg <= 1'b1;
                    end
                end
                S_KEEP:
                begin
                    if (keep_cur)
                    begin
                        if (f_reg < POLY_MAX)
                        begin
                            f_reg <= f_reg + 4'd1;
                        end
                        else
                        begin
                            over_reg <= 1'b1;
                        end
                    end
                end
                S_IWAIT:
                begin
                    if (interp_done)
                    begin
                        if (f_reg < POLY_MAX)
                        begin
                            f_reg <= f_reg + 4'd1;
                        end
                        else
                        begin
                            over_reg <= 1'b1;
                        end
                    end
                end
                S_ADV:
                begin
                    i_reg <= i_reg + 4'd1;
                end
                S_PEND:
                begin
                    n_reg     <= f_reg;
                    bank_reg  <= ~bank_reg;
                    plane_reg <= plane_reg + 3'd1;
                end
                S_FINAL:
                begin
                    e_reg <= 4'd0;
                end
                S_OLD:
                begin
                    if (out_load)
                    begin
                        e_reg <= e_reg + 4'd1;
                        if (out_is_last)
                        begin
                            used_reg <= used_sum[10:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Vertex and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tri_reg <= s_axis_tdata[179:0];
        end
        case (state_reg)
            S_RD0:
            begin
                first_p_reg <= ram_rd_data;
                cur_p_reg   <= ram_rd_data;
            end
            S_D0:
            begin
                if (dist_done)
                begin
                    first_d_reg <= dist_res;
                    cur_d_reg   <= dist_res;
                end
            end
            S_NEXT:
            begin
                if (i_reg + 4'd1 == n_reg)
                begin
                    nxt_p_reg <= first_p_reg;
                    nxt_d_reg <= first_d_reg;
                end
            end
            S_NRD:
            begin
                nxt_p_reg <= ram_rd_data;
            end
            S_ND:
            begin
                if (dist_done)
                begin
                    nxt_d_reg <= dist_res;
                end
            end
            S_ADV:
            begin
                cur_p_reg <= nxt_p_reg;
                cur_d_reg <= nxt_d_reg;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_v_reg    <= ram_rd_data;
            out_idx_reg  <= used_reg[9:0] + {6'b0, e_reg};
            out_size_reg <= n_reg;
            out_last_reg <= out_is_last;
        end
    end

    tbc_ram #(
        .WIDTH (VW),
        .DEPTH (RAM_DEPTH)
    ) u_vram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr ({(state_reg == S_LOAD) ? bank_reg : ~bank_reg, ram_wr_idx}),
        .wr_data (ram_wr_data),
        .rd_addr ({bank_reg, rd_idx}),
        .rd_data (ram_rd_data)
    );

    tbc_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dist_start),
        .vtx     (ram_rd_data),
        .axis    (axis_sel),
        .origin  (origin_reg),
        .radius  (radius_reg),
        .epsilon (eps_reg),
        .flip    (plane_reg[0]),
        .res     (dist_res),
        .done    (dist_done)
    );

    tbc_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (interp_start),
        .v_vtx (cur_p_reg),
        .w_vtx (nxt_p_reg),
        .dv    (cur_d_reg.plane_dist),
        .dw    (nxt_d_reg.plane_dist),
        .res   (interp_res),
        .done  (interp_done)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_size_reg, out_idx_reg, out_v_reg};
    assign m_axis_tlast  = out_last_reg;

    // Checks
    `TBC_ASSERT_IMP(a_wr_bound, clk, rst_n, ram_we, ram_wr_idx < POLY_MAX)
    `TBC_ASSERT_IMP(a_used_cap, clk, rst_n, 1'b1, used_reg <= OUTPUT_VERTS)
    `TBC_ASSERT_IMP(a_plane_size, clk, rst_n, state_reg == S_FETCH0,
        n_reg != 4'd0 && n_reg <= POLY_MAX)
    `TBC_ASSERT_NXT(a_dist_latency, clk, rst_n, dist_start, !dist_done)

endmodule

[test/testbench.sv]
// Self-checking testbench for the triangle box clipper: random and directed triangles
// go in on the slave stream, and clipped vertices are checked against a built-in predictor.
// Depends on tbc_pkg and triangle_box_clipper_top.
module testbench;
    import tbc_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 4000;

    typedef struct {
        logic         start;
        logic [183:0] data;
    } triangle_t;

    typedef struct {
        logic [19:0] x;
        logic [19:0] y;
        logic [19:0] z;
        logic [9:0]  index;
        logic [3:0]  size;
        logic        last;
    } vertex_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [59:0]  cfg_data = '0;

    triangle_t pending_triangles[$];
    vertex_t   expected_vertices[$];
    triangle_t in_flight;
    int        send_gap;
    int        recv_gap;
    int        error_count;
    bit        steady;

    // Configuration copy used by the predictor
    logic [47:0] axis_reg[3];
    logic [59:0] origin_reg;
    logic [18:0] radius_reg;
    logic [18:0] epsilon_reg;
    logic [10:0] max_vert_reg;
    int          vertices_used;

    triangle_box_clipper_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] error: %s", $time, what);
        error_count++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    // Interpolate one coordinate across a crossing edge, round half away from zero
    function automatic int cross_coord(input int v, input int w, input longint dv,
                                       input longint dw);
        longint          den;
        longint          num;
        longint unsigned mag;
        longint unsigned q;
        longint          r;
        bit              neg;
        den = dv - dw;
        num = (longint'(w) - longint'(v)) * dv;
        if (den == 0)
            return v;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        neg = num < 0;
        mag = neg ? longint'(-num) : num;
        q = (2 * mag + longint'(den)) / (2 * longint'(den));
        r = longint'(v) + (neg ? -longint'(q) : longint'(q));
        if (r > 524287)
            r = 524287;
        if (r < -524288)
            r = -524288;
        return int'(r);
    endfunction

    // Clip one triangle against the six box planes and queue the surviving vertices
    function automatic void clip_triangle(input triangle_t t);
        int      poly[2][16][3];
        int      count[2];
        longint  plane_dist[16];
        side_t   side[16];
        longint  rad;
        longint  eps;
        longint  d;
        int      cur;
        int      f;
        int      j;
        int      n;
        int      budget;
        bit      front;
        bit      over;
        vertex_t v;
        if (t.start)
            vertices_used = 0;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                poly[0][i][k] = $signed(t.data[20 * (3 * i + k) +: 20]);
        count[0] = 3;
        cur = 0;
        rad = longint'(radius_reg) * 16384;
        eps = longint'(epsilon_reg) * 16384;
        for (int plane = 0; plane < 6; plane++)
        begin
            front = 1'b0;
            over = 1'b0;
            f = 0;
            for (int i = 0; i < count[cur]; i++)
            begin
                d = 0;
                for (int k = 0; k < 3; k++)
                    d += (longint'(poly[cur][i][k])
                          - longint'($signed(origin_reg[20 * k +: 20])))
                         * longint'($signed(axis_reg[plane / 2][16 * k +: 16]));
                if (plane % 2 == 1)
                    d = -d;
                d += rad;
                plane_dist[i] = d;
                if (d > eps)
                begin
                    side[i] = SIDE_AHEAD;
                    front = 1'b1;
                end
                else if (d < -eps)
                    side[i] = SIDE_BEHIND;
                else
                    side[i] = SIDE_ON;
            end
            // Drop when nothing lies strictly in front
            if (!front)
                return;
            for (int i = 0; i < count[cur]; i++)
            begin
                j = (i + 1 == count[cur]) ? 0 : i + 1;
                if (side[i] != SIDE_BEHIND)
                begin
                    if (f < 16)
                    begin
                        poly[cur ^ 1][f] = poly[cur][i];
                        f++;
                    end
                    else
                        over = 1'b1;
                end
                if (side[i] == SIDE_ON || side[j] == SIDE_ON || side[i] == side[j])
                    continue;
                if (f < 16)
                begin
                    for (int k = 0; k < 3; k++)
                        poly[cur ^ 1][f][k] = cross_coord(poly[cur][i][k], poly[cur][j][k],
                                                          plane_dist[i], plane_dist[j]);
                    f++;
                end
                else
                    over = 1'b1;
            end
            // Drop an oversized polygon
            if (over || f > int'(POLY_MAX))
                return;
            count[cur ^ 1] = f;
            cur ^= 1;
        end
        n = count[cur];
        budget = (max_vert_reg < OUTPUT_VERTS) ? int'(max_vert_reg) : int'(OUTPUT_VERTS);
        if (n < 3 || vertices_used + n > budget)
            return;
        for (int i = 0; i < n; i++)
        begin
            v.x = 20'(poly[cur][i][0]);
            v.y = 20'(poly[cur][i][1]);
            v.z = 20'(poly[cur][i][2]);
            v.index = 10'(vertices_used + i);
            v.size = 4'(n);
            v.last = (i == n - 1);
            expected_vertices.push_back(v);
        end
        vertices_used += n;
    endfunction

    // Driver: present queued triangles, predict on each transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                clip_triangle(in_flight);
            if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_triangles.size() > 0)
            begin
                in_flight = pending_triangles.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= in_flight.data;
                s_axis_tuser <= in_flight.start;
                send_gap = draw_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: stall at random and check each vertex transfer
    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_vertices.size() == 0)
                    report_mismatch("vertex transfer with none expected");
                else
                begin
                    e = expected_vertices.pop_front();
                    if (m_axis_tdata[19:0] !== e.x)
                        report_mismatch($sformatf("out_x %h, want %h", m_axis_tdata[19:0], e.x));
                    if (m_axis_tdata[39:20] !== e.y)
                        report_mismatch($sformatf("out_y %h, want %h", m_axis_tdata[39:20], e.y));
                    if (m_axis_tdata[59:40] !== e.z)
                        report_mismatch($sformatf("out_z %h, want %h", m_axis_tdata[59:40], e.z));
                    if (m_axis_tdata[69:60] !== e.index)
                        report_mismatch($sformatf("buffer_index %0d, want %0d",
                                                  m_axis_tdata[69:60], e.index));
                    if (m_axis_tdata[73:70] !== e.size)
                        report_mismatch($sformatf("poly_size %0d, want %0d",
                                                  m_axis_tdata[73:70], e.size));
                    if (m_axis_tlast !== e.last)
                        report_mismatch($sformatf("last %b, want %b", m_axis_tlast, e.last));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    recv_gap = draw_gap();
            end
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [59:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            REG_AXIS_ZERO:    axis_reg[0] = value[47:0];
            REG_AXIS_ONE:     axis_reg[1] = value[47:0];
            REG_AXIS_TWO:     axis_reg[2] = value[47:0];
            REG_BOX_ORIGIN:   origin_reg = value;
            REG_BOX_RADIUS:   radius_reg = value[18:0];
            REG_ON_EPSILON:   epsilon_reg = value[18:0];
            REG_MAX_VERTICES: max_vert_reg = value[10:0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every triangle is taken and every vertex has arrived, then settle
    task automatic drain();
        while (pending_triangles.size() != 0 || s_axis_tvalid || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [47:0] pack_axis(input int ax, input int ay, input int az);
        return {16'(az), 16'(ay), 16'(ax)};
    endfunction

    task automatic push_triangle(input logic start, input int c[9]);
        triangle_t t;
        t.start = start;
        t.data = '0;
        for (int i = 0; i < 9; i++)
            t.data[20 * i +: 20] = 20'(c[i]);
        pending_triangles.push_back(t);
    endtask

    // Random triangle: mostly around the box, sometimes anywhere
    task automatic push_random(input int count);
        int c[9];
        int span;
        int centre;
        for (int n = 0; n < count; n++)
        begin
            span = int'(radius_reg) * 2 + 64;
            if (span > 400000)
                span = 400000;
            for (int i = 0; i < 9; i++)
            begin
                centre = $signed(origin_reg[20 * (i % 3) +: 20]);
                if ($urandom_range(0, 99) < 85)
                    c[i] = centre + int'($urandom_range(0, 2 * span)) - span;
                else
                    c[i] = int'($urandom_range(0, 20'hFFFFF)) - 524288;
            end
            push_triangle($urandom_range(0, 9) == 0, c);
        end
    endtask

    initial
    begin
        int r;
        error_count = 0;
        send_gap = 0;
        recv_gap = 0;
        steady = 1'b0;
        axis_reg[0] = 48'd16384;
        axis_reg[1] = 48'd1073741824;
        axis_reg[2] = 48'd70368744177664;
        origin_reg = '0;
        radius_reg = 19'd0;
        epsilon_reg = 19'd6;
        max_vert_reg = 11'd1024;
        vertices_used = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: a zero-size box drops everything
        push_triangle(1'b1, '{0, 0, 0, 64, 0, 0, 0, 64, 0});
        push_triangle(1'b0, '{-524288, -524288, -524288, -524288, -524288, -524288,
                              -524288, -524288, -524288});
        push_triangle(1'b0, '{524287, 524287, 524287, 524287, 524287, 524287,
                              524287, 524287, 524287});
        drain();

        // Axis-aligned box of half extent 100
        write_reg(REG_AXIS_ZERO, 60'(pack_axis(16384, 0, 0)));
        write_reg(REG_AXIS_ONE, 60'(pack_axis(0, 16384, 0)));
        write_reg(REG_AXIS_TWO, 60'(pack_axis(0, 0, 16384)));
        write_reg(REG_BOX_ORIGIN, '0);
        write_reg(REG_BOX_RADIUS, 60'd6400);
        write_reg(REG_ON_EPSILON, 60'd6);
        write_reg(REG_MAX_VERTICES, 60'd1024);
        write_reg(REG_UNUSED, 60'hFFFFFFFFFFFFFFF);
        steady = 1'b1;
        // Fully inside
        push_triangle(1'b1, '{0, 0, 0, 640, 0, 0, 0, 640, 0});
        // Crosses one plane
        push_triangle(1'b0, '{0, 0, 0, 12800, 0, 0, 0, 640, 0});
        // Crosses corners on several planes
        push_triangle(1'b0, '{-9000, -9000, 0, 9000, -9000, 100, 0, 9000, -200});
        // Vertex on a plane, within the tolerance band
        push_triangle(1'b0, '{6400, 0, 0, 0, 640, 0, 0, 0, 640});
        push_triangle(1'b0, '{6403, 6397, 0, -6400, 0, 0, 0, -6400, 0});
        // Whole triangle outside
        push_triangle(1'b0, '{20000, 0, 0, 21000, 0, 0, 20000, 500, 0});
        // Extreme coordinates crossing the box
        push_triangle(1'b0, '{-524288, 0, 0, 524287, 0, 0, 0, 100, 100});
        push_triangle(1'b0, '{-524288, -524288, -524288, 524287, 524287, 524287,
                              524287, -524288, 0});
        drain();

        // Drop a triangle that would run past the budget, restart the batch
        steady = 1'b0;
        write_reg(REG_MAX_VERTICES, 60'd10);
        push_triangle(1'b1, '{0, 0, 0, 640, 0, 0, 0, 640, 0});
        push_triangle(1'b0, '{0, 0, 0, 12800, 0, 0, 0, 640, 0});
        push_triangle(1'b0, '{0, 0, 0, 640, 0, 0, 0, 640, 0});
        push_triangle(1'b0, '{0, 0, 0, 640, 0, 0, 0, 640, 0});
        push_triangle(1'b1, '{0, 0, 0, 640, 0, 0, 0, 640, 0});
        push_random(50);
        drain();

        // Empty budget, then a budget above the buffer size; zero tolerance
        write_reg(REG_MAX_VERTICES, 60'd0);
        write_reg(REG_ON_EPSILON, 60'd0);
        push_triangle(1'b1, '{0, 0, 0, 640, 0, 0, 0, 640, 0});
        drain();
        write_reg(REG_MAX_VERTICES, 60'd2047);
        push_random(50);
        drain();

        // Largest radius and tolerance, offset origin
        write_reg(REG_BOX_RADIUS, 60'h7FFFF);
        write_reg(REG_ON_EPSILON, 60'h7FFFF);
        write_reg(REG_BOX_ORIGIN, {20'h7FFFF, 20'h80000, 20'h00100});
        push_random(20);
        drain();
        write_reg(REG_ON_EPSILON, 60'd64);
        write_reg(REG_BOX_RADIUS, 60'd20000);
        push_random(30);
        drain();

        // Tilted axes and random origin
        write_reg(REG_AXIS_ZERO, 60'(pack_axis(11585, 11585, 0)));
        write_reg(REG_AXIS_ONE, 60'(pack_axis(-11585, 11585, 0)));
        write_reg(REG_AXIS_TWO, 60'(pack_axis(0, 0, -16384)));
        write_reg(REG_BOX_ORIGIN, {20'(int'($urandom_range(0, 20000)) - 10000),
                                   20'(int'($urandom_range(0, 20000)) - 10000),
                                   20'(int'($urandom_range(0, 20000)) - 10000)});
        write_reg(REG_BOX_RADIUS, 60'($urandom_range(100, 30000)));
        write_reg(REG_ON_EPSILON, 60'($urandom_range(0, 200)));
        write_reg(REG_MAX_VERTICES, 60'($urandom_range(100, 1024)));
        push_random(60);
        drain();

        // Fully random registers
        for (int p = 0; p < 2; p++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r = i;
                write_reg(3'(r), 60'({$urandom, $urandom}));
            end
            write_reg(REG_BOX_RADIUS, 60'({$urandom, $urandom}));
            write_reg(REG_ON_EPSILON, 60'($urandom_range(0, 1000)));
            write_reg(REG_MAX_VERTICES, 60'({$urandom, $urandom}));
            push_random(35);
            drain();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20 * 3000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
